>>> src/round_robin_thread_scheduler_macros.svh
// Assertion macros for the round-robin thread scheduler.
// Used by the top level only; no dependencies.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rrts_pkg.sv
// Shared constants, types and helpers for the round-robin thread scheduler.
// No dependencies.
package rrts_pkg;

  localparam int THREAD_SLOTS = 6;
  localparam int COND_COUNT   = 4;

  localparam int SLOT_W = $clog2(THREAD_SLOTS);
  localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
  localparam int COND_W = (COND_COUNT > 1) ? $clog2(COND_COUNT) : 1;

  localparam logic [2:0] CMD_SPAWN = 3'd0;
  localparam logic [2:0] CMD_YIELD = 3'd1;
  localparam logic [2:0] CMD_EXIT  = 3'd2;
  localparam logic [2:0] CMD_WAIT  = 3'd3;
  localparam logic [2:0] CMD_BCAST = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_SLOT = 2'd1;
  localparam logic [1:0] STS_NO_RUN  = 2'd2;
  localparam logic [1:0] STS_HALTED  = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [COND_W-1:0] cond_t;

  typedef struct packed {
    logic latch_in;
    logic scan_start;
    logic scan_step;
    logic spawn_commit;
    logic push_cur;
    logic exit_cur;
    logic wait_push;
    logic rd_ready;
    logic pop_ready;
    logic set_halt;
    logic set_no_slot;
    logic set_already;
    logic rd_wait;
    logic bc_move;
    logic bc_clear;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cond_ok;
    logic       halted;
    logic       scan_free;
    logic       scan_last;
    logic       ready_empty;
    logic       wait_empty;
  } dp_stat_t;

  function automatic slot_t slot_inc(slot_t p);
    return (p == slot_t'(THREAD_SLOTS - 1)) ? '0 : p + slot_t'(1);
  endfunction

endpackage

>>> src/rrts_ctrl.sv
// Sequencing state machine of the thread scheduler.
// Depends on rrts_pkg; drives rrts_dpath through dp_cmd_t.
module rrts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rrts_pkg::dp_stat_t stat,
  output rrts_pkg::dp_cmd_t  ctl
);
  import rrts_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_PICK_RD  = 9'b000001000,
    S_PICK_POP = 9'b000010000,
    S_BC_CHK   = 9'b000100000,
    S_BC_MOVE  = 9'b001000000,
    S_DONE     = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        if (stat.halted) begin
          ctl.set_already = 1'b1;
        end else begin
          unique case (stat.op)
            CMD_SPAWN: begin
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            CMD_YIELD: begin
              ctl.push_cur = 1'b1;
              state_next   = S_PICK_RD;
            end
            CMD_EXIT: begin
              ctl.exit_cur = 1'b1;
              state_next   = S_PICK_RD;
            end
            CMD_WAIT: begin
              if (stat.cond_ok) begin
                ctl.wait_push = 1'b1;
                state_next    = S_PICK_RD;
              end
            end
            CMD_BCAST: begin
              if (stat.cond_ok) state_next = S_BC_CHK;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        priority if (stat.scan_free) begin
          ctl.spawn_commit = 1'b1;
          state_next       = S_DONE;
        end else if (stat.scan_last) begin
          ctl.set_no_slot = 1'b1;
          state_next      = S_DONE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_PICK_RD: begin
        if (stat.ready_empty) begin
          ctl.set_halt = 1'b1;
          state_next   = S_DONE;
        end else begin
          ctl.rd_ready = 1'b1;
          state_next   = S_PICK_POP;
        end
      end
      S_PICK_POP: begin
        ctl.pop_ready = 1'b1;
        state_next    = S_DONE;
      end
      S_BC_CHK: begin
        if (stat.wait_empty) begin
          ctl.bc_clear = 1'b1;
          state_next   = S_DONE;
        end else begin
          ctl.rd_wait = 1'b1;
          state_next  = S_BC_MOVE;
        end
      end
      S_BC_MOVE: begin
        ctl.bc_move = 1'b1;
        state_next  = S_BC_CHK;
      end
      S_DONE: begin
        if (emit) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/rrts_dpath.sv
// Datapath of the thread scheduler: slot claims, ready FIFO, wait FIFOs,
// counters and result word. Depends on rrts_pkg; commanded by rrts_ctrl.
module rrts_dpath (
  input  logic               clk,
  input  logic               rst,
  input  rrts_pkg::dp_cmd_t  ctl,
  input  logic [2:0]         cmd,
  input  logic [1:0]         cond_sel,
  output rrts_pkg::dp_stat_t stat,
  output logic [1:0]         status,
  output logic [2:0]         spawned_id,
  output logic [2:0]         running_id,
  output logic               switched,
  output logic [31:0]        switch_total,
  output logic [2:0]         live_total
);
  import rrts_pkg::*;

  logic [2:0]              op_q;
  logic [1:0]              cond_q;
  cond_t                   cidx;
  logic [THREAD_SLOTS-1:0] used;
  slot_t                   scan_idx;

  slot_t rq_mem [THREAD_SLOTS];
  slot_t rq_head, rq_tail, rq_rd;
  cnt_t  rq_count;

  slot_t wq_mem  [COND_COUNT][THREAD_SLOTS];
  slot_t wq_head [COND_COUNT];
  slot_t wq_tail [COND_COUNT];
  cnt_t  wq_count[COND_COUNT];
  slot_t wq_rd;

  slot_t       cur;
  slot_t       live;
  logic [31:0] sw_count;
  logic        halted;

  logic [1:0] res_status;
  slot_t      res_spawned;
  logic       res_switched;

  logic  push_en, push_ok, wq_ok;
  slot_t push_data;

  assign cidx      = cond_t'(cond_q);
  assign push_en   = ctl.spawn_commit | ctl.push_cur | ctl.bc_move;
  assign push_ok   = push_en && (rq_count < cnt_t'(THREAD_SLOTS));
  assign wq_ok     = ctl.wait_push && (wq_count[cidx] < cnt_t'(THREAD_SLOTS));

  always_comb begin
    priority if (ctl.spawn_commit) push_data = scan_idx;
    else if (ctl.push_cur)         push_data = cur;
    else                           push_data = wq_rd;
  end

  always_comb begin
    stat.op          = op_q;
    stat.cond_ok     = ({30'd0, cond_q} < 32'(COND_COUNT));
    stat.halted      = halted;
    stat.scan_free   = !used[scan_idx];
    stat.scan_last   = (scan_idx == slot_t'(THREAD_SLOTS - 1));
    stat.ready_empty = (rq_count == '0);
    stat.wait_empty  = (wq_count[cidx] == '0);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) rq_mem[rq_tail] <= push_data;
    if (ctl.rd_ready) rq_rd <= rq_mem[rq_head];
    if (wq_ok) wq_mem[cidx][wq_tail[cidx]] <= cur;
    if (ctl.rd_wait) wq_rd <= wq_mem[cidx][wq_head[cidx]];
  end

  // payload: input word, scan pointer, result word
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      op_q         <= cmd;
      cond_q       <= cond_sel;
      res_status   <= STS_OK;
      res_spawned  <= '0;
      res_switched <= 1'b0;
    end
    if (ctl.scan_start) scan_idx <= slot_t'(1);
    if (ctl.scan_step)  scan_idx <= scan_idx + slot_t'(1);
    if (ctl.spawn_commit) res_spawned <= scan_idx;
    if (ctl.pop_ready)    res_switched <= 1'b1;
    if (ctl.set_no_slot)  res_status <= STS_NO_SLOT;
    if (ctl.set_halt)     res_status <= STS_NO_RUN;
    if (ctl.set_already)  res_status <= STS_HALTED;
    if (ctl.load_out) begin
      status       <= res_status;
      spawned_id   <= 3'(res_spawned);
      running_id   <= 3'(cur);
      switched     <= res_switched;
      switch_total <= sw_count;
      live_total   <= 3'(live);
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= THREAD_SLOTS'(1);
      rq_head  <= '0;
      rq_tail  <= '0;
      rq_count <= '0;
      for (int i = 0; i < COND_COUNT; i++) begin
        wq_head[i]  <= '0;
        wq_tail[i]  <= '0;
        wq_count[i] <= '0;
      end
      cur      <= '0;
      live     <= '0;
      sw_count <= '0;
      halted   <= 1'b0;
    end else begin
      if (ctl.spawn_commit) begin
        used[scan_idx] <= 1'b1;
        live           <= live + slot_t'(1);
      end
      if (ctl.exit_cur && (live != '0)) live <= live - slot_t'(1);
      if (push_ok) begin
        rq_tail  <= slot_inc(rq_tail);
        rq_count <= rq_count + cnt_t'(1);
      end
      if (ctl.pop_ready) begin
        rq_head  <= slot_inc(rq_head);
        rq_count <= rq_count - cnt_t'(1);
        cur      <= rq_rd;
        sw_count <= sw_count + 32'd1;
      end
      if (ctl.set_halt) halted <= 1'b1;
      if (wq_ok) begin
        wq_tail[cidx]  <= slot_inc(wq_tail[cidx]);
        wq_count[cidx] <= wq_count[cidx] + cnt_t'(1);
      end
      if (ctl.bc_move) begin
        wq_head[cidx]  <= slot_inc(wq_head[cidx]);
        wq_count[cidx] <= wq_count[cidx] - cnt_t'(1);
      end
      if (ctl.bc_clear) begin
        wq_head[cidx] <= '0;
        wq_tail[cidx] <= '0;
      end
    end
  end

endmodule

>>> src/round_robin_thread_scheduler.sv
// Round-robin thread scheduler, top level: controller plus datapath.
// Depends on rrts_pkg, rrts_ctrl, rrts_dpath and the assertion macro header.
//
// One command word in, one result word out; one command is in flight at a
// time. Yield pushes the current thread onto the ready queue and wait pushes
// it onto its wait queue; yield, exit and wait then read the ready queue and
// pop the next thread, and an exit or wait that finds the ready queue empty
// halts. Spawn scans from slot 1, one slot a cycle, for the first unused slot
// and reports no slot when none is free; broadcast moves its waiters one at a
// time, each read through the wait-queue memory read port and then pushed onto
// the ready queue. A finished result sits in the output register until taken;
// the next command is accepted once that register has been loaded.
module round_robin_thread_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [1:0]  cond_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [2:0]  spawned_id,
  output logic [2:0]  running_id,
  output logic        switched,
  output logic [31:0] switch_total,
  output logic [2:0]  live_total
);
  import rrts_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  rrts_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .cond_sel     (cond_sel),
    .stat         (stat),
    .status       (status),
    .spawned_id   (spawned_id),
    .running_id   (running_id),
    .switched     (switched),
    .switch_total (switch_total),
    .live_total   (live_total)
  );

`include "round_robin_thread_scheduler_macros.svh"

  `RRTS_ASSERT_NXT(a_halt_sticky, clk, rst, stat.halted, stat.halted, "halt cleared")
  `RRTS_ASSERT_NXT(a_halt_status, clk, rst, ctl.load_out, ((status == STS_NO_RUN) || (status == STS_HALTED)) == stat.halted, "status disagrees with halt")
  `RRTS_ASSERT_IMP(a_switch_ok, clk, rst, out_valid && switched, status == STS_OK, "switch with bad status")
  `RRTS_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second word taken mid-command")

endmodule

>>> sim/thread_sched_check.sv
`timescale 1ns / 1ps
// Checker for the round-robin thread scheduler: watches both channels, predicts each result
// word and compares it field by field. Depends on rrts_pkg.
module thread_sched_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [1:0]  cond_sel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [2:0]  spawned_id,
  input  logic [2:0]  running_id,
  input  logic        switched,
  input  logic [31:0] switch_total,
  input  logic [2:0]  live_total,
  output int          fail_count,
  output int          pending,
  output int          ready_depth,
  output int          live_now,
  output logic        halted_now
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    SLOT_UNUSED,
    SLOT_READY,
    SLOT_RUNNING,
    SLOT_WAITING,
    SLOT_EXITED
  } lifecycle_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  spawned_id;
    logic [2:0]  running_id;
    logic        switched;
    logic [31:0] switch_total;
    logic [2:0]  live_total;
  } sched_word_t;

  lifecycle_t  life [THREAD_SLOTS];
  slot_t       run_fifo [$];
  slot_t       cond_fifo [COND_COUNT][$];
  slot_t       cur_thread;
  cnt_t        live_cnt;
  logic [31:0] switch_cnt;
  logic        halt_flag;
  sched_word_t due_results [$];
  int          fails = 0;

  assign fail_count = fails;

  function automatic void clear_model();
    foreach (life[i]) life[i] = SLOT_UNUSED;
    life[0] = SLOT_RUNNING;
    run_fifo.delete();
    foreach (cond_fifo[c]) cond_fifo[c].delete();
    cur_thread = '0;
    live_cnt   = '0;
    switch_cnt = '0;
    halt_flag  = 1'b0;
  endfunction

  function automatic void enqueue_ready(slot_t t);
    if (run_fifo.size() < THREAD_SLOTS) run_fifo.push_back(t);
  endfunction

  function automatic logic [1:0] dispatch_next(inout logic sw);
    slot_t t;
    if (run_fifo.size() == 0) begin
      if (life[cur_thread] == SLOT_RUNNING) return STS_OK;
      halt_flag = 1'b1;
      return STS_NO_RUN;
    end
    t = run_fifo.pop_front();
    life[t] = SLOT_RUNNING;
    cur_thread = t;
    switch_cnt = switch_cnt + 32'd1;
    sw = 1'b1;
    return STS_OK;
  endfunction

  function automatic sched_word_t apply_command(logic [2:0] op, logic [1:0] cs);
    sched_word_t r;
    slot_t       cur;
    slot_t       t;
    logic        sw;
    int          found;
    r = '0;
    sw = 1'b0;
    cur = cur_thread;
    found = 0;
    if (halt_flag) begin
      r.status = STS_HALTED;
    end else begin
      case (op)
        CMD_SPAWN: begin
          for (int i = THREAD_SLOTS - 1; i >= 1; i--)
            if (life[i] == SLOT_UNUSED) found = i;
          if (found == 0) begin
            r.status = STS_NO_SLOT;
          end else begin
            life[found] = SLOT_READY;
            enqueue_ready(slot_t'(found));
            live_cnt = live_cnt + cnt_t'(1);
            r.spawned_id = 3'(found);
          end
        end
        CMD_YIELD: begin
          life[cur] = SLOT_READY;
          enqueue_ready(cur);
          r.status = dispatch_next(sw);
        end
        CMD_EXIT: begin
          life[cur] = SLOT_EXITED;
          if (live_cnt != 0) live_cnt = live_cnt - cnt_t'(1);
          r.status = dispatch_next(sw);
        end
        CMD_WAIT: begin
          if (int'(cs) < COND_COUNT) begin
            life[cur] = SLOT_WAITING;
            if (cond_fifo[cs].size() < THREAD_SLOTS) cond_fifo[cs].push_back(cur);
            r.status = dispatch_next(sw);
          end
        end
        CMD_BCAST: begin
          if (int'(cs) < COND_COUNT) begin
            while (cond_fifo[cs].size() > 0) begin
              t = cond_fifo[cs].pop_front();
              life[t] = SLOT_READY;
              enqueue_ready(t);
            end
          end
        end
        default: ;
      endcase
    end
    r.running_id   = cur_thread;
    r.switched     = sw;
    r.switch_total = switch_cnt;
    r.live_total   = live_cnt;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sched_word_t want;
    if (rst) begin
      clear_model();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with none expected");
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("spawned_id", 64'(want.spawned_id), 64'(spawned_id));
          check_field("running_id", 64'(want.running_id), 64'(running_id));
          check_field("switched", 64'(want.switched), 64'(switched));
          check_field("switch_total", 64'(want.switch_total), 64'(switch_total));
          check_field("live_total", 64'(want.live_total), 64'(live_total));
        end
      end
      if (in_valid && in_ready) due_results.push_back(apply_command(cmd, cond_sel));
    end
    pending     <= due_results.size();
    ready_depth <= run_fifo.size();
    live_now    <= int'(live_cnt);
    halted_now  <= halt_flag;
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the round-robin thread scheduler: drives command words with random
// gaps and stalls, and gives the verdict. Depends on rrts_pkg and thread_sched_check.
module tb;
  import rrts_pkg::*;

  localparam logic [2:0] CMD_TOP      = 3'd7;
  localparam int         RANDOM_WORDS = 1900;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 20;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [2:0]  cmd       = CMD_SPAWN;
  logic [1:0]  cond_sel  = 2'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status;
  logic [2:0]  spawned_id;
  logic [2:0]  running_id;
  logic        switched;
  logic [31:0] switch_total;
  logic [2:0]  live_total;
  int          fail_count;
  int          pending;
  int          ready_depth;
  int          live_now;
  logic        halted_now;
  int          send_idle = 37;
  int          recv_idle = 78;
  int          cycles    = 0;

  always #4 clk = ~clk;

  round_robin_thread_scheduler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .cond_sel(cond_sel),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .spawned_id(spawned_id), .running_id(running_id),
    .switched(switched), .switch_total(switch_total), .live_total(live_total)
  );

  thread_sched_check chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .cond_sel(cond_sel),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .spawned_id(spawned_id), .running_id(running_id),
    .switched(switched), .switch_total(switch_total), .live_total(live_total),
    .fail_count(fail_count), .pending(pending), .ready_depth(ready_depth),
    .live_now(live_now), .halted_now(halted_now)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one word per call; returns after acceptance so predicted state is current
  task automatic send_cmd(logic [2:0] op, logic [1:0] cs);
    while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    cmd      <= op;
    cond_sel <= cs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  // mostly legal traffic; never starves the ready queue until the wind-down
  task automatic random_step(output bit counted);
    logic [2:0] op;
    logic [1:0] cs;
    int         r;
    r  = $urandom_range(0, 99);
    cs = 2'($urandom_range(0, COND_COUNT - 1));
    if (r < 4) op = 3'($urandom_range(int'(CMD_BCAST) + 1, int'(CMD_TOP)));
    else if (r < 8) op = CMD_SPAWN;
    else if (r < 11 && live_now > 2 && ready_depth > 0) op = CMD_EXIT;
    else if (r < 45) op = CMD_YIELD;
    else if (r < 75 && ready_depth > 0) op = CMD_WAIT;
    else op = CMD_BCAST;
    send_cmd(op, cs);
    counted = (op <= CMD_BCAST);
  endtask

  initial begin
    int done;
    bit counted;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int op = int'(CMD_BCAST) + 1; op <= int'(CMD_TOP); op++) send_cmd(3'(op), 2'(op));
    send_cmd(CMD_BCAST, 2'd0);
    send_cmd(CMD_YIELD, 2'd0);
    repeat (THREAD_SLOTS) send_cmd(CMD_SPAWN, 2'd0);
    repeat (2) send_cmd(CMD_YIELD, 2'd3);
    send_cmd(CMD_WAIT, 2'd0);
    send_cmd(CMD_WAIT, 2'd3);
    send_cmd(CMD_WAIT, 2'd1);
    send_cmd(CMD_WAIT, 2'd2);
    send_cmd(CMD_BCAST, 2'd3);
    send_cmd(CMD_BCAST, 2'd0);
    send_cmd(CMD_YIELD, 2'd1);
    send_cmd(CMD_BCAST, 2'd1);
    send_cmd(CMD_BCAST, 2'd2);
    send_cmd(CMD_EXIT, 2'd1);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 78;
        recv_idle = 37;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      done = 0;
      while (done < RANDOM_WORDS / 3) begin
        random_step(counted);
        if (counted) done++;
      end
      drain();
    end

    // release every waiter, then exit threads until the scheduler halts
    for (int c = 0; c < COND_COUNT; c++) send_cmd(CMD_BCAST, 2'(c));
    while (!halted_now) send_cmd(CMD_EXIT, 2'($urandom_range(0, COND_COUNT - 1)));
    repeat (8) send_cmd(3'($urandom_range(0, int'(CMD_TOP))), 2'($urandom_range(0, 3)));
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
